// ===== design/pqe_pkg.sv =====
// Shared types and constants for the product-quantization encoder.
`default_nettype none
package pqe_pkg;
   localparam int ValueWidth  = 16;
   localparam int AccWidth    = 38;
   localparam int SubWidth    = 4;
   localparam int CentWidth   = 8;
   localparam int CompWidth   = 4;
   localparam int StoreAwidth = SubWidth + CentWidth + CompWidth;
   localparam int QueueDepth  = 2;

   localparam logic [1:0] CSR_NUM_SUBSPACES = 2'd0;
   localparam logic [1:0] CSR_NUM_CENTROIDS = 2'd1;
   localparam logic [1:0] CSR_SUB_DIM       = 2'd2;

   // Classified item handed from front to back.
   typedef struct packed {
      logic                        is_load;
      logic signed [ValueWidth-1:0] value;
      logic [StoreAwidth-1:0]      addr;      // load address or stream base
      logic                        first;     // first component of subspace
      logic                        emit;      // last component of subspace
      logic [SubWidth-1:0]         subspace;
      logic                        last_code;
   } work_type;
endpackage
`default_nettype wire

// ===== design/pqe_front.sv =====
// Front part: configuration, stream position tracking and item classification.
`default_nettype none
module pqe_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_index,
   input  wire logic [8:0]          csr_data,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [32:0]         in_data,
   output logic                     wk_valid,
   input  wire logic                wk_ready,
   output pqe_pkg::work_type        wk_item,
   output logic [8:0]               k_eff
);
   logic [4:0] nsub_ff, dim_ff;
   logic [8:0] ncent_ff;
   logic [3:0] spos_ff, cpos_ff;
   logic [4:0] m_eff, d_eff;
   logic       op;
   logic       emit, lastv;
   logic [3:0] spos_in, cpos_in;

   assign csr_ready = 1'b1;
   assign in_ready  = wk_ready;
   assign wk_valid  = in_valid;
   assign op        = in_data[0];

   // Saturate registers into their legal range
   always_comb begin
      m_eff = (nsub_ff == 5'd0) ? 5'd1 : (nsub_ff > 5'd16 ? 5'd16 : nsub_ff);
      d_eff = (dim_ff == 5'd0) ? 5'd1 : (dim_ff > 5'd16 ? 5'd16 : dim_ff);
      k_eff = (ncent_ff == 9'd0) ? 9'd1 : (ncent_ff > 9'd256 ? 9'd256 : ncent_ff);
   end

   // Classify and advance positions
   always_comb begin
      emit    = ({1'b0, cpos_ff} + 5'd1) >= d_eff;
      lastv   = ({1'b0, spos_ff} + 5'd1) >= m_eff;
      cpos_in = emit ? 4'd0 : cpos_ff + 4'd1;
      spos_in = emit ? (lastv ? 4'd0 : spos_ff + 4'd1) : spos_ff;
      wk_item.is_load   = !op;
      wk_item.value     = in_data[16:1];
      wk_item.addr      = op ? {spos_ff, 8'd0, cpos_ff}
                             : {in_data[20:17], in_data[28:21], in_data[32:29]};
      wk_item.first     = cpos_ff == 4'd0;
      wk_item.emit      = emit;
      wk_item.subspace  = spos_ff;
      wk_item.last_code = lastv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nsub_ff  <= 5'd8;
         ncent_ff <= 9'd256;
         dim_ff   <= 5'd4;
         spos_ff  <= '0;
         cpos_ff  <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pqe_pkg::CSR_NUM_SUBSPACES: nsub_ff  <= csr_data[4:0];
               pqe_pkg::CSR_NUM_CENTROIDS: ncent_ff <= csr_data;
               pqe_pkg::CSR_SUB_DIM:       dim_ff   <= csr_data[4:0];
               default: ;
            endcase
         end
         if (in_valid && wk_ready && op) begin
            spos_ff <= spos_in;
            cpos_ff <= cpos_in;
         end
      end
   end
endmodule
`default_nettype wire

// ===== design/pqe_queue.sv =====
// Short queue between front and back parts.
`default_nettype none
module pqe_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  pqe_pkg::work_type      wr_item,
   output logic                   rd_valid,
   input  wire logic              rd_ready,
   output pqe_pkg::work_type      rd_item
);
   pqe_pkg::work_type mem_ff [pqe_pkg::QueueDepth];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_item  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_item;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule
`default_nettype wire

// ===== design/pqe_back.sv =====
// Back part: codebook memory, per-centroid accumulators and nearest search.
`default_nettype none
module pqe_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wk_valid,
   output logic                   wk_ready,
   input  pqe_pkg::work_type      wk_item,
   input  wire logic [8:0]        k_eff,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic                   rsp_tlast
);
   typedef enum logic [1:0] {IDLE, RUN, DRAIN, HOLD} state_type;

   logic [15:0] store_mem [1 << pqe_pkg::StoreAwidth];
   logic [37:0] acc_mem [256];

   state_type   state_ff;
   pqe_pkg::work_type cur_ff;
   logic [8:0]  k_ff;           // issue counter
   logic [8:0]  kend_ff;
   logic        p1_ff, p2_ff;   // pipeline valid
   logic [7:0]  k1_ff, k2_ff;
   logic [15:0] cen_ff;
   logic [37:0] acc_rd_ff;
   logic [31:0] sq_ff;
   logic [37:0] best_ff;
   logic [7:0]  bidx_ff;
   logic        bval_ff;
   logic signed [16:0] diff;
   logic [16:0] mag;
   logic [37:0] sum;
   logic [7:0]  code_ff;
   logic [3:0]  sub_ff;
   logic        last_ff;

   assign wk_ready   = state_ff == IDLE;
   assign rsp_tvalid = state_ff == HOLD;
   assign rsp_tdata  = {4'd0, sub_ff, code_ff};
   assign rsp_tlast  = last_ff;

   // Stage 1 difference magnitude; stage 2 sum of the square and the prior accumulator (zero on a first component)
   always_comb begin
      diff = $signed({cur_ff.value[15], cur_ff.value}) - $signed({cen_ff[15], cen_ff});
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      sum  = (cur_ff.first ? 38'd0 : acc_rd_ff) + {6'd0, sq_ff};
   end

   always_ff @(posedge clock) begin
      // Stage 0: codebook read
      cen_ff    <= store_mem[{cur_ff.addr[15:12], k_ff[7:0], cur_ff.addr[3:0]}];
      k1_ff     <= k_ff[7:0];
      // Stage 1: multiply, accumulator read lined up with the square
      sq_ff     <= 32'(mag) * 32'(mag);
      acc_rd_ff <= acc_mem[k1_ff];
      k2_ff     <= k1_ff;
      // Stage 2: writeback
      if (p2_ff) acc_mem[k2_ff] <= sum;
      if (state_ff == IDLE && wk_valid && wk_item.is_load)
         store_mem[wk_item.addr] <= wk_item.value;

      if (reset) begin
         state_ff <= IDLE;
         p1_ff <= 1'b0; p2_ff <= 1'b0; bval_ff <= 1'b0;
      end else begin
         p1_ff <= state_ff == RUN;
         p2_ff <= p1_ff;
         if (p2_ff && cur_ff.emit) begin
            if (!bval_ff || sum < best_ff) begin
               best_ff <= sum; bidx_ff <= k2_ff;
            end
            bval_ff <= 1'b1;
         end
         unique case (state_ff)
            IDLE: if (wk_valid && !wk_item.is_load) begin
               cur_ff <= wk_item; k_ff <= 9'd0; kend_ff <= k_eff;
               bval_ff <= 1'b0; state_ff <= RUN;
            end
            RUN: begin
               k_ff <= k_ff + 9'd1;
               if (k_ff + 9'd1 == kend_ff) state_ff <= DRAIN;
            end
            DRAIN: if (!p1_ff && !p2_ff) begin
               if (cur_ff.emit) begin
                  code_ff <= bidx_ff; sub_ff <= cur_ff.subspace;
                  last_ff <= cur_ff.last_code; state_ff <= HOLD;
               end else state_ff <= IDLE;
            end
            HOLD: if (rsp_tready) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== design/pq_nearest_centroid_encode_top.sv =====
// Top level of the product-quantization nearest-centroid encoder.
//  channel | direction | fields (low bit up)
//  req     | in        | tuser: op; tdata: value, load_subspace, load_centroid, load_component
//  rsp     | out       | tdata: code, subspace; tlast: last_code
//  csr     | in        | index 0..2, data
// A load item is written to the codebook store while the back part is idle. A vector
// item makes one accumulator update a cycle through a three-stage read, square, add
// pipeline, then drains it; an item that ends a subspace then yields a code.
// A code holds the back part until taken; the two-entry queue takes up to two more
// items before req_tready drops.
// Reset clears positions and restores the default configuration; the stores need no clearing.
`default_nettype none
module pq_nearest_centroid_encode_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value, load_subspace, load_centroid, load_component
   input  wire logic        req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // code, subspace
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_data
);
   pqe_pkg::work_type f_item, b_item;
   logic f_valid, f_ready, b_valid, b_ready;
   logic [8:0] k_eff;

   pqe_front u_front (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data({req_tdata, req_tuser}),
      .wk_valid(f_valid), .wk_ready(f_ready), .wk_item(f_item), .k_eff);

   pqe_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item));

   pqe_back u_back (
      .clock, .reset, .wk_valid(b_valid), .wk_ready(b_ready), .wk_item(b_item),
      .k_eff, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast);
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the product-quantization nearest-centroid encoder.
`default_nettype none
module tb_top;
   typedef struct {
      bit        op;
      bit [15:0] value;
      bit [3:0]  lsub;
      bit [7:0]  lcent;
      bit [3:0]  lcomp;
   } req_item_type;

   typedef struct {
      bit [7:0] code;
      bit [3:0] subspace;
      bit       last_code;
   } code_item_type;

   typedef struct {
      req_item_type  it;
      bit            typed;
      code_item_type res;
   } row_type;

   localparam bit OP_LOAD = 1'b0;
   localparam bit OP_VEC  = 1'b1;
   localparam int DrainCycles = 1000;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;

   pq_nearest_centroid_encode_top dut (.*);

   // Encoder state mirrored in the testbench
   bit signed [15:0] codebook [65536];
   bit               loaded   [65536];
   longint unsigned  dist_sum [256];
   bit [3:0]         sub_at, comp_at;
   bit [4:0]         reg_subspaces, reg_dims;
   bit [8:0]         reg_centroids;
   code_item_type    code_q[$];

   int  mismatches = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  long_hold = 0;
   int  hold_cnt = 0;

   function automatic int clamp_reg(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int eff_subspaces();
      return clamp_reg(int'(reg_subspaces), 16);
   endfunction
   function automatic int eff_centroids();
      return clamp_reg(int'(reg_centroids), 256);
   endfunction
   function automatic int eff_dims();
      return clamp_reg(int'(reg_dims), 16);
   endfunction

   function automatic int book_addr(int s, int k, int d);
      return (s * 256 + k) * 16 + d;
   endfunction

   // Advance the encoder by one item; returns 1 when it yields a code
   function automatic bit encode_step(req_item_type it, output code_item_type r);
      longint signed x, diff;
      longint unsigned best;
      int kn, bi;
      r = '{default: 0};
      if (it.op == OP_LOAD) begin
         codebook[book_addr(int'(it.lsub), int'(it.lcent), int'(it.lcomp))] = it.value;
         loaded[book_addr(int'(it.lsub), int'(it.lcent), int'(it.lcomp))]   = 1;
         return 0;
      end
      kn = eff_centroids();
      x  = $signed(it.value);
      for (int k = 0; k < kn; k++) begin
         diff = x - longint'(codebook[book_addr(int'(sub_at), k, int'(comp_at))]);
         if (diff < 0) diff = -diff;
         dist_sum[k] = ((comp_at == 0) ? 0 : dist_sum[k]) + diff * diff;
      end
      if (int'(comp_at) + 1 < eff_dims()) begin
         comp_at++;
         return 0;
      end
      best = dist_sum[0];
      bi   = 0;
      for (int k = 1; k < kn; k++)
         if (dist_sum[k] < best) begin
            best = dist_sum[k];
            bi   = k;
         end
      r.code      = 8'(bi);
      r.subspace  = sub_at;
      r.last_code = (int'(sub_at) + 1 >= eff_subspaces());
      comp_at = 4'd0;
      sub_at  = r.last_code ? 4'd0 : sub_at + 4'd1;
      return 1;
   endfunction

   // Clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver: random stalls plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (long_hold && hold_cnt == 0) begin
         hold_cnt   = 3000;
         long_hold  = 0;
         rsp_tready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      code_item_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (code_q.size() == 0) begin
            $error("code item with none expected: code %0d", rsp_tdata[7:0]);
            mismatches++;
         end else begin
            e = code_q.pop_front();
            if (rsp_tdata[7:0] !== e.code) begin
               $error("code: expected %0d, got %0d", e.code, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[11:8] !== e.subspace) begin
               $error("subspace: expected %0d, got %0d", e.subspace, rsp_tdata[11:8]);
               mismatches++;
            end
            if (rsp_tlast !== e.last_code) begin
               $error("last_code: expected %0d, got %0d", e.last_code, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, bit [8:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         pqe_pkg::CSR_NUM_SUBSPACES: reg_subspaces = val[4:0];
         pqe_pkg::CSR_NUM_CENTROIDS: reg_centroids = val;
         pqe_pkg::CSR_SUB_DIM:       reg_dims      = val[4:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(bit [8:0] m, bit [8:0] k, bit [8:0] d);
      write_reg(pqe_pkg::CSR_NUM_SUBSPACES, m);
      write_reg(pqe_pkg::CSR_NUM_CENTROIDS, k);
      write_reg(pqe_pkg::CSR_SUB_DIM, d);
   endtask

   task automatic drain();
      wait (code_q.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_item(req_item_type it, bit typed = 0,
                            code_item_type tr = '{default: 0});
      code_item_type r;
      req_tvalid <= 1;
      req_tuser  <= it.op;
      req_tdata  <= {it.lcomp, it.lcent, it.lsub, it.value};
      do @(posedge clock); while (!req_tready);
      if (encode_step(it, r) && !typed) code_q.push_back(r);
      if (typed) code_q.push_back(tr);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic bit [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3, 4: return 16'($signed($urandom_range(4)) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // Vector component; codebook entries it will read get loaded first
   task automatic send_component();
      req_item_type it;
      for (int k = 0; k < eff_centroids(); k++)
         if (!loaded[book_addr(int'(sub_at), k, int'(comp_at))]) begin
            it = '{OP_LOAD, pick_value(), sub_at, 8'(k), comp_at};
            send_item(it);
         end
      it = '{OP_VEC, pick_value(), 4'($urandom), 8'($urandom), 4'($urandom)};
      send_item(it);
   endtask

   task automatic run_phase(int items);
      req_item_type it;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(9) == 0) begin
            // stray load anywhere in the codebook
            it = '{OP_LOAD, pick_value(), 4'($urandom), 8'($urandom), 4'($urandom)};
            send_item(it);
         end
         send_component();
      end
   endtask

   row_type steps[] = '{
      '{'{OP_LOAD, 16'h8000, 4'd0, 8'd0, 4'd0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 16'h7fff, 4'd0, 8'd1, 4'd0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 16'h0000, 4'd1, 8'd0, 4'd0}, 0, '{0, 0, 0}},
      '{'{OP_LOAD, 16'h0000, 4'd1, 8'd1, 4'd0}, 0, '{0, 0, 0}},
      '{'{OP_VEC,  16'h8000, 4'hf, 8'hff, 4'hf}, 1, '{8'd0, 4'd0, 1'b0}},
      '{'{OP_VEC,  16'h7fff, 4'd0, 8'd0, 4'd0},  1, '{8'd0, 4'd1, 1'b1}},
      '{'{OP_VEC,  16'h7fff, 4'd0, 8'd0, 4'd0},  1, '{8'd1, 4'd0, 1'b0}},
      '{'{OP_VEC,  16'h8000, 4'd0, 8'd0, 4'd0},  1, '{8'd0, 4'd1, 1'b1}},
      // overwrite centroid 1 of subspace 1 so centroid 1 wins there for values above 128
      '{'{OP_LOAD, 16'h0100, 4'd1, 8'd1, 4'd0}, 0, '{0, 0, 0}},
      '{'{OP_VEC,  16'h0000, 4'd0, 8'd0, 4'd0},  0, '{0, 0, 0}},
      '{'{OP_VEC,  16'h00ff, 4'd0, 8'd0, 4'd0},  0, '{0, 0, 0}},
      '{'{OP_VEC,  16'hffff, 4'd0, 8'd0, 4'd0},  0, '{0, 0, 0}},
      '{'{OP_VEC,  16'h0080, 4'd0, 8'd0, 4'd0},  0, '{0, 0, 0}}
   };

   // Stimulus
   initial begin
      int m, k, d;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      csr_valid  = 0;
      csr_index  = pqe_pkg::CSR_NUM_SUBSPACES;
      csr_data   = '0;
      sub_at = 0; comp_at = 0;
      reg_subspaces = 8; reg_centroids = 256; reg_dims = 4;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part
      set_shape(9'd2, 9'd2, 9'd1);
      foreach (steps[i]) send_item(steps[i].it, steps[i].typed, steps[i].res);
      req_tvalid <= 0;
      drain();

      // Reset shape, one component only (part of a vector)
      set_shape(9'd8, 9'd256, 9'd4);
      run_phase(1);
      req_tvalid <= 0;
      drain();

      // Zero registers act as one; mid-vector positions are kept
      set_shape(9'd0, 9'd0, 9'd0);
      run_phase(10);
      req_tvalid <= 0;
      drain();

      // Over-range registers saturate to the largest shape
      set_shape(9'h1f, 9'h1ff, 9'h1f);
      run_phase(1);
      req_tvalid <= 0;
      drain();

      // Over-range subspace count and dimension with a small codebook
      set_shape(9'h1f, 9'd2, 9'h1f);
      run_phase(20);
      req_tvalid <= 0;
      drain();

      // Random shapes under every idling mode
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 33; recv_stall_pct = 33; end
         endcase
         m = $urandom_range(1, 16);
         k = $urandom_range(1, 8);
         d = $urandom_range(1, 6);
         set_shape(9'(m), 9'(k), 9'(d));
         run_phase(6);
         if (ph == 5) begin
            // long receiver hold-off while items keep coming
            req_tvalid <= 0;
            drain();
            set_shape(9'd1, 9'd2, 9'd1);
            long_hold = 1;
            run_phase(20);
         end
         req_tvalid <= 0;
         drain();
      end

      if (mismatches == 0 && code_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
design/pqe_pkg.sv
design/pqe_front.sv
design/pqe_queue.sv
design/pqe_back.sv
design/pq_nearest_centroid_encode_top.sv
dv/tb_top.sv
